@@ src/shuffled_lehmer_uniform_generator_defines.svh @@
// Assertion macros for the shuffled Lehmer uniform generator.
`ifndef SHUFFLED_LEHMER_UNIFORM_GENERATOR_DEFINES_SVH
`define SHUFFLED_LEHMER_UNIFORM_GENERATOR_DEFINES_SVH
`ifndef SYNTHESIS
// expr must hold at every clock edge outside reset
`define SLUG_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);
// cond at one edge implies expr at the next edge
`define SLUG_ASSERT_NEXT(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (expr)) \
        else $error(msg);
`else
`define SLUG_ASSERT_ALWAYS(lbl, expr, msg)
`define SLUG_ASSERT_NEXT(lbl, cond, expr, msg)
`endif
`endif

@@ src/slug_pkg.sv @@
// Constants shared by the shuffled Lehmer uniform generator.
package slug_pkg;

    localparam int unsigned TABLE_DEPTH  = 32;
    localparam int unsigned WARMUP_EXTRA = 8;
    localparam int unsigned LCG_MULT     = 16807;
    localparam int unsigned LCG_MOD      = 32'h7FFF_FFFF;
    localparam int unsigned SLOT_DIV     = 1 + (LCG_MOD - 1) / TABLE_DEPTH;

    localparam int unsigned ADDR_W  = $clog2(TABLE_DEPTH);
    localparam int unsigned WARM_W  = $clog2(TABLE_DEPTH + WARMUP_EXTRA);
    localparam int unsigned PROD_W  = 47;

    typedef logic [30:0] sample_t;
    typedef logic [ADDR_W-1:0] addr_t;

    typedef enum logic {
        KIND_DRAW   = 1'b0,
        KIND_RESEED = 1'b1
    } kind_t;

endpackage

@@ src/shuffled_lehmer_uniform_generator.sv @@
// Shuffled Lehmer uniform generator: Park-Miller step with a shuffle table.
//
// Input stream (s_*): s_tuser is the item kind (0 draws one sample, 1 loads
// a new seed), s_tdata carries the signed 32-bit seed. A seed load produces
// nothing. A draw produces one item on the output stream (m_*), whose
// m_tdata holds the 31-bit numerator of value/2147483647.
//
// A draw runs on one shared multiply-and-fold unit: each Lehmer step is a
// multiply state, then a fold mod 2^31-1 state. The slot index is the last
// output divided by the slot width (a shift with 32 slots), then the table is
// read and written. A plain draw passes the multiply, fold, read and
// write-back states; m_tvalid rises as write-back ends, with s_tready high
// again in that cycle, so no draw is taken while one runs; seed loads run
// at one per cycle when idle. Reinit adds TABLE_DEPTH + 8 warm-up steps.
//
// Reset clears the seed and last output, so the first draw reinitializes;
// the table needs no clearing since it is always filled before it is read.
// A finished item waits in the output register while the receiver stalls;
// the next draw runs meanwhile and holds at its write-back step, with
// s_tready low, until the register frees.
`include "shuffled_lehmer_uniform_generator_defines.svh"

module shuffled_lehmer_uniform_generator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] seed_value
    input  logic        s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [30:0] sample, [31] zero
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_RED  = 3'd2;
    localparam logic [2:0] ST_RD   = 3'd4;
    localparam logic [2:0] ST_WB   = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [31:0] seed_reg, seed_next;
    slug_pkg::sample_t last_reg, last_next;
    logic [31:0] s_reg, s_next;
    logic [slug_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic        warm_reg, warm_next;
    logic [slug_pkg::WARM_W-1:0] k_reg, k_next;
    slug_pkg::addr_t q_reg, q_next;
    logic        out_valid_reg, out_valid_next;
    slug_pkg::sample_t out_data_reg, out_data_next;

    slug_pkg::sample_t table_mem [slug_pkg::TABLE_DEPTH];
    slug_pkg::sample_t rd_reg;

    logic        in_fire;
    logic        need_init;
    logic [31:0] init_seed;
    logic [31:0] fold_sum;
    logic [31:0] fold_val;
    slug_pkg::sample_t red_val;
    logic        out_free;
    logic        wr_en;
    slug_pkg::addr_t wr_addr;
    slug_pkg::sample_t wr_data;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_data_reg};
    assign out_free = !out_valid_reg || m_tready;

    // Zero or negative seed, or a zero last output, forces a warm-up
    assign need_init = seed_reg[31] || (seed_reg == 32'd0) || (last_reg == '0);
    assign init_seed = seed_reg[31] ? (~seed_reg + 32'd1) : 32'd1;

    // Fold the product: 2^31 == 1 mod 2^31-1, then one conditional subtract
    assign fold_sum = 32'(prod_reg[slug_pkg::PROD_W-1:31]) + {1'b0, prod_reg[30:0]};
    assign fold_val = (fold_sum >= slug_pkg::LCG_MOD) ? (fold_sum - slug_pkg::LCG_MOD)
                                                      : fold_sum;
    assign red_val  = fold_val[30:0];

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = q_reg;
        wr_data = seed_reg[30:0];
        if ((state_reg == ST_RED) && warm_reg
            && (k_reg < slug_pkg::WARM_W'(slug_pkg::TABLE_DEPTH))) begin
            wr_en   = 1'b1;
            wr_addr = k_reg[slug_pkg::ADDR_W-1:0];
            wr_data = red_val;
        end else if ((state_reg == ST_WB) && out_free) begin
            wr_en = 1'b1;
        end
    end

    always_comb begin
        state_next     = state_reg;
        seed_next      = seed_reg;
        last_next      = last_reg;
        s_next         = s_reg;
        prod_next      = prod_reg;
        warm_next      = warm_reg;
        k_next         = k_reg;
        q_next         = q_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (s_tuser == slug_pkg::KIND_DRAW) begin
                        state_next = ST_MUL;
                        if (need_init) begin
                            s_next    = init_seed;
                            warm_next = 1'b1;
                            k_next    = slug_pkg::WARM_W'(slug_pkg::TABLE_DEPTH
                                                          + slug_pkg::WARMUP_EXTRA - 1);
                        end else begin
                            s_next    = seed_reg;
                            warm_next = 1'b0;
                        end
                    end else begin
                        seed_next = s_tdata;
                    end
                end
            end
            ST_MUL: begin
                prod_next  = slug_pkg::PROD_W'(s_reg)
                             * slug_pkg::PROD_W'(slug_pkg::LCG_MULT);
                state_next = ST_RED;
            end
            ST_RED: begin
                s_next = {1'b0, red_val};
                if (warm_reg) begin
                    state_next = ST_MUL;
                    if (k_reg == '0) begin
                        // table[0] was just written with this value
                        last_next = red_val;
                        warm_next = 1'b0;
                    end else begin
                        k_next = k_reg - slug_pkg::WARM_W'(1);
                    end
                end else begin
                    seed_next  = {1'b0, red_val};
                    q_next     = slug_pkg::addr_t'(last_reg / slug_pkg::SLOT_DIV);
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                state_next = ST_WB;
            end
            ST_WB: begin
                // hold until the output register is free
                if (out_free) begin
                    out_data_next  = rd_reg;
                    out_valid_next = 1'b1;
                    last_next      = rd_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            seed_reg      <= '0;
            last_reg      <= '0;
            warm_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            seed_reg      <= seed_next;
            last_reg      <= last_next;
            warm_reg      <= warm_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s_reg        <= s_next;
        prod_reg     <= prod_next;
        k_reg        <= k_next;
        q_reg        <= q_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem[wr_addr] <= wr_data;
        end
        rd_reg <= table_mem[q_reg];
    end

    `SLUG_ASSERT_ALWAYS(a_fold_in_range, (state_reg != ST_RED) || (fold_val < slug_pkg::LCG_MOD), "fold result not reduced")
    `SLUG_ASSERT_NEXT(a_draw_starts, in_fire && (s_tuser == slug_pkg::KIND_DRAW), state_reg == ST_MUL, "draw did not start")
    `SLUG_ASSERT_NEXT(a_wb_loads_out, (state_reg == ST_WB) && out_free, out_valid_reg && (state_reg == ST_IDLE), "write-back lost its item")
    `SLUG_ASSERT_NEXT(a_reseed_loads, in_fire && (s_tuser != slug_pkg::KIND_DRAW), seed_reg == $past(s_tdata), "seed load missed")

endmodule

@@ tb/sv/tb_shuffled_lehmer_uniform_generator.sv @@
// Self-checking testbench for the shuffled Lehmer uniform generator stream block.
module tb_shuffled_lehmer_uniform_generator;

    // Drain margin covers the longest draw, a reinitializing one with its warm-up steps
    localparam int DRAIN_CYCLES  = 16 + slug_pkg::ADDR_W
                                   + 2 * (slug_pkg::TABLE_DEPTH + slug_pkg::WARMUP_EXTRA);
    localparam int QUIET_LIMIT   = 4000;
    localparam int STALL_CYCLES  = 400;
    localparam logic [31:0] SPECIAL_SEEDS [6] = '{
        32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF,
        32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFF
    };

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [31:0] seed_value
    logic        s_tuser  = 1'b0; // [0] kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // [30:0] sample, [31] zero

    shuffled_lehmer_uniform_generator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Generator state as the block should hold it
    logic [31:0]       model_seed = '0;
    slug_pkg::sample_t model_last = '0;
    slug_pkg::sample_t model_slots [slug_pkg::TABLE_DEPTH];

    slug_pkg::sample_t expected_samples [$];
    int      err_count    = 0;
    int      src_idle_pct = 0;
    int      snk_idle_pct = 0;
    int      stall_left   = 0;
    int      quiet_cycles = 0;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic longint unsigned lehmer_step(longint unsigned s);
        return (s * slug_pkg::LCG_MULT) % slug_pkg::LCG_MOD;
    endfunction

    task automatic predict_item(slug_pkg::kind_t kind, logic [31:0] value);
        longint            sv;
        longint unsigned   s;
        int unsigned       slot;
        slug_pkg::sample_t sample;
        if (kind == slug_pkg::KIND_RESEED) begin
            model_seed = value;
            return;
        end
        sv = longint'($signed(model_seed));
        if (sv <= 0 || model_last == '0) begin
            // restart from a sane seed, then warm up and refill every slot top-down
            if (sv >= 0)
                s = 1;
            else
                s = -sv;
            for (int k = slug_pkg::TABLE_DEPTH + slug_pkg::WARMUP_EXTRA - 1; k >= 0; k--) begin
                s = lehmer_step(s);
                if (k < int'(slug_pkg::TABLE_DEPTH))
                    model_slots[k] = s[30:0];
            end
            model_last = model_slots[0];
        end else begin
            s = sv;
        end
        s = lehmer_step(s);
        model_seed = s[31:0];
        slot = model_last / slug_pkg::SLOT_DIV;
        if (slot > slug_pkg::TABLE_DEPTH - 1)
            slot = slug_pkg::TABLE_DEPTH - 1;
        sample = model_slots[slot];
        model_last = sample;
        model_slots[slot] = s[30:0];
        expected_samples.push_back(sample);
    endtask

    task automatic report_mismatch(string msg);
        err_count++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    // Offer one item and hold it until the block takes it; leave tvalid as is afterward
    task automatic send_item(slug_pkg::kind_t kind, logic [31:0] value);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        predict_item(kind, value);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Receiver: check each accepted sample, then pick tready for the next cycle
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_samples.size() == 0) begin
                report_mismatch($sformatf("unexpected sample %h", m_tdata));
            end else begin
                slug_pkg::sample_t want;
                want = expected_samples.pop_front();
                if (m_tdata[30:0] !== want)
                    report_mismatch($sformatf("sample %h, expected %h", m_tdata[30:0], want));
                if (m_tdata[31] !== 1'b0)
                    report_mismatch("padding bit of sample is not zero");
            end
        end
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic test_draw_after_reset();
        // zero seed and zero last output both force a fresh start
        send_item(slug_pkg::KIND_DRAW, 32'hFFFF_FFFF);
        send_item(slug_pkg::KIND_DRAW, 32'h0000_0000);
        send_item(slug_pkg::KIND_DRAW, $urandom());
        drain_results();
    endtask

    task automatic test_seed_extremes();
        foreach (SPECIAL_SEEDS[i]) begin
            send_item(slug_pkg::KIND_RESEED, SPECIAL_SEEDS[i]);
            send_item(slug_pkg::KIND_DRAW, $urandom());
            send_item(slug_pkg::KIND_DRAW, $urandom());
        end
        // back-to-back seed loads: only the latter counts
        send_item(slug_pkg::KIND_RESEED, 32'h8000_0000);
        send_item(slug_pkg::KIND_RESEED, 32'h0001_E240);
        send_item(slug_pkg::KIND_DRAW, $urandom());
        drain_results();
    endtask

    task automatic test_zero_sample();
        int tries;
        tries = 0;
        // modulus seed without a restart steps to zero and plants it in the table
        send_item(slug_pkg::KIND_DRAW, $urandom());
        send_item(slug_pkg::KIND_RESEED, 32'h7FFF_FFFF);
        send_item(slug_pkg::KIND_DRAW, $urandom());
        send_item(slug_pkg::KIND_RESEED, $urandom_range(32'h7FFF_FFFE, 1));
        while (model_last != '0 && tries < 600) begin
            send_item(slug_pkg::KIND_DRAW, $urandom());
            tries++;
        end
        // zero last output forces a restart here
        send_item(slug_pkg::KIND_DRAW, $urandom());
        send_item(slug_pkg::KIND_DRAW, $urandom());
        drain_results();
    endtask

    task automatic test_output_stall();
        stall_left = STALL_CYCLES;
        repeat (12) send_item(slug_pkg::KIND_DRAW, $urandom());
        drain_results();
    endtask

    task automatic test_random_stream(int count);
        logic [31:0] value;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 8) begin
                if ($urandom_range(3) == 0)
                    value = SPECIAL_SEEDS[$urandom_range(5)];
                else
                    value = $urandom();
                send_item(slug_pkg::KIND_RESEED, value);
            end else begin
                send_item(slug_pkg::KIND_DRAW, $urandom());
            end
        end
        drain_results();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle_pct = 11;
        snk_idle_pct = 73;
        test_draw_after_reset();
        test_seed_extremes();
        test_zero_sample();
        test_random_stream(450);

        src_idle_pct = 73;
        snk_idle_pct = 11;
        test_random_stream(450);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_output_stall();
        test_random_stream(450);

        if (expected_samples.size() != 0)
            report_mismatch($sformatf("%0d samples never arrived", expected_samples.size()));
        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
